// ----- design/cdq_pkg.sv -----
// Shared definitions for the circular double-ended queue.
// Holds operation and status codes, default sizes and the response info struct.
// Depends on nothing; used by every module of the block.
package cdq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned DATA_W        = 32;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_FULL       = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_UNUSED     = 2'd3
	} status_t;

	// Travels with a transaction from the pointer stage to the output stage.
	typedef struct packed {
		logic    valid;
		status_t status;
	} rsp_info_t;

endpackage

// ----- design/circular_deque_top.sv -----
// Circular double-ended queue: one transaction per clock, busy never asserts.
// done is start delayed through info_s1 and info_s2, in step with the store read.
// Throughput: one transaction per cycle; the pointer update and store write are
// followed by the registered store read of front and rear.
// Reset clears pointers, count and strobes; store contents stay undefined until pushed.
// The receiver cannot stall: each result is shown for exactly one cycle on done.
module circular_deque_top #(
	parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
	localparam int unsigned IDX_W = $clog2(DEPTH),
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic        [1:0]                 operation,
	input  logic signed [cdq_pkg::DATA_W-1:0] value,
	output logic                              done,
	output logic        [1:0]                 status,
	output logic signed [cdq_pkg::DATA_W-1:0] front_value,
	output logic signed [cdq_pkg::DATA_W-1:0] rear_value,
	output logic                              is_empty,
	output logic                              is_full,
	output logic        [CNT_W-1:0]           occupancy
);

	logic                       wr_en;
	logic [IDX_W-1:0]           wr_addr;
	logic [cdq_pkg::DATA_W-1:0] wr_data;
	logic [IDX_W-1:0]           head_q;
	logic [IDX_W-1:0]           tail_q;
	logic [CNT_W-1:0]           cnt_q;
	cdq_pkg::rsp_info_t         info_s1;
	cdq_pkg::rsp_info_t         info_s2;
	logic [CNT_W-1:0]           cnt_s2;
	logic [cdq_pkg::DATA_W-1:0] front_s2;
	logic [cdq_pkg::DATA_W-1:0] rear_s2;

	assign busy = 1'b0;

	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (cdq_pkg::op_t'(operation)),
		.value   (value),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.head_q  (head_q),
		.tail_q  (tail_q),
		.cnt_q   (cnt_q),
		.info_s1 (info_s1)
	);

	cdq_store #(.DEPTH(DEPTH)) u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.front_addr (head_q),
		.rear_addr  (tail_q),
		.front_s2   (front_s2),
		.rear_s2    (rear_s2)
	);

	// The pointer registers hold the state left by the stage-one transaction,
	// so the count is captured here alongside the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s2 <= '{valid: 1'b0, status: cdq_pkg::ST_DONE};
			cnt_s2  <= '0;
		end else begin
			info_s2 <= info_s1;
			cnt_s2  <= cnt_q;
		end
	end

	assign done        = info_s2.valid;
	assign status      = info_s2.status;
	assign is_empty    = (cnt_s2 == '0);
	assign is_full     = (cnt_s2 == CNT_W'(DEPTH));
	assign occupancy   = cnt_s2;
	assign front_value = is_empty ? '0 : signed'(front_s2);
	assign rear_value  = is_empty ? '0 : signed'(rear_s2);

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("transaction result did not appear two cycles after start");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty && is_full))
		else $error("queue reported empty and full at once");

	a_empty_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == cdq_pkg::ST_EMPTY |-> is_empty)
		else $error("empty rejection reported with elements held");

endmodule

// ----- design/cdq_ctrl.sv -----
// Pointer and count control of the circular double-ended queue.
// Decides each transaction, updates head, tail and count, and issues the store write.
// Depends on cdq_pkg.
module cdq_ctrl #(
	parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
	localparam int unsigned IDX_W = $clog2(DEPTH),
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  cdq_pkg::op_t                      op,
	input  logic        [cdq_pkg::DATA_W-1:0] value,
	output logic                              wr_en,
	output logic        [IDX_W-1:0]           wr_addr,
	output logic        [cdq_pkg::DATA_W-1:0] wr_data,
	output logic        [IDX_W-1:0]           head_q,
	output logic        [IDX_W-1:0]           tail_q,
	output logic        [CNT_W-1:0]           cnt_q,
	output cdq_pkg::rsp_info_t                info_s1
);

	logic [IDX_W-1:0]   head_d;
	logic [IDX_W-1:0]   tail_d;
	logic [CNT_W-1:0]   cnt_d;
	cdq_pkg::status_t   status_d;
	logic               full;
	logic               empty;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
		return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr_data = value;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		status_d = cdq_pkg::ST_DONE;
		wr_en    = 1'b0;
		wr_addr  = '0;
		case (op)
			cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
				if (full) begin
					status_d = cdq_pkg::ST_FULL;
				end else if (empty) begin
					// The first element always lands in slot zero.
					head_d  = '0;
					tail_d  = '0;
					cnt_d   = CNT_W'(1);
					wr_en   = start;
					wr_addr = '0;
				end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
					head_d  = wrap_dec(head_q);
					cnt_d   = cnt_q + CNT_W'(1);
					wr_en   = start;
					wr_addr = head_d;
				end else begin
					tail_d  = wrap_inc(tail_q);
					cnt_d   = cnt_q + CNT_W'(1);
					wr_en   = start;
					wr_addr = tail_d;
				end
			end
			default: begin
				if (empty) begin
					status_d = cdq_pkg::ST_EMPTY;
				end else if (cnt_q == CNT_W'(1)) begin
					// The indices are left stale; the next push resets them.
					cnt_d = '0;
				end else if (op == cdq_pkg::OP_POP_FRONT) begin
					head_d = wrap_inc(head_q);
					cnt_d  = cnt_q - CNT_W'(1);
				end else begin
					tail_d = wrap_dec(tail_q);
					cnt_d  = cnt_q - CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			info_s1 <= '{valid: 1'b0, status: cdq_pkg::ST_DONE};
		end else begin
			info_s1.valid <= start;
			if (start) begin
				head_q         <= head_d;
				tail_q         <= tail_d;
				cnt_q          <= cnt_d;
				info_s1.status <= status_d;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds its depth");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		start && status_d != cdq_pkg::ST_DONE
		|=> $stable(cnt_q) && $stable(head_q) && $stable(tail_q))
		else $error("rejected transaction changed the queue state");

	a_wr_only_push: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> start && !full
			&& (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR))
		else $error("store written without an accepted push");

endmodule

// ----- design/cdq_store.sv -----
// Element store of the circular double-ended queue.
// One write port and two registered read ports for the front and rear elements.
// Depends on cdq_pkg for the element width.
module cdq_store #(
	parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
	localparam int unsigned IDX_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [cdq_pkg::DATA_W-1:0] wr_data,
	input  logic [IDX_W-1:0]           front_addr,
	input  logic [IDX_W-1:0]           rear_addr,
	output logic [cdq_pkg::DATA_W-1:0] front_s2,
	output logic [cdq_pkg::DATA_W-1:0] rear_s2
);

	logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

	// Reads return the old contents when the same entry is written at the same edge;
	// a transaction that writes then reads its own entry in the following cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		front_s2 <= mem[front_addr];
		rear_s2  <= mem[rear_addr];
	end

endmodule
